FILE: hdl/surb_pkg.sv
// Package with the shared types and constants of the serial-to-USB ring bridge.
`default_nettype none

package surb_pkg;

  localparam int unsigned CfgWidth  = 7;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned FillWidth = 6;

  localparam logic [CfgWidth-1:0] EarlySendFreeReset = 7'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_STAT,
    S_SEND
  } surb_state_t;

endpackage

`default_nettype wire

FILE: hdl/serial_to_usb_ring_bridge_top.sv
// Serial-to-USB byte ring bridge: a byte ring that drops its oldest byte when full.
//
// The input channel carries one word per event: a received serial byte or a flush
// timer tick, together with the current USB accept flag. The output channel gives
// one word per sent byte, the final one marked by last, or one status word when
// nothing is sent. Every word carries the drop, refusal, timer and fill status.
// The single register early_send_free is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle; the block itself does not enforce this.
// An accepted word is evaluated in the next cycle; the ring sits in a RAM with a
// registered read port. A status-only word is offered once the evaluation has
// chosen the status state. A burst of n bytes reads the RAM one entry per cycle
// while the output does not stall, so its words appear at one per cycle, and the
// next input is taken only after the burst, or the status word, has been loaded.
// A stall on the output holds the output word and pauses the RAM reads; the
// input is stalled until the current word's last result has been loaded.
// Reset clears both indexes, stops the flush timer and restores the register to
// its default. The ring contents are not cleared.
`default_nettype none

module serial_to_usb_ring_bridge_top #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [surb_pkg::CfgWidth-1:0]     cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              action,
  input  wire logic [surb_pkg::ByteWidth-1:0]    rx_byte,
  input  wire logic                              usb_accept,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   byte_valid,
  output logic      [surb_pkg::ByteWidth-1:0]    tx_byte,
  output logic                                   last,
  output logic                                   dropped,
  output logic                                   send_refused,
  output logic                                   timer_running,
  output logic      [surb_pkg::FillWidth-1:0]    fill_level
);

  import surb_pkg::*;

  localparam int unsigned IW = $clog2(RING_DEPTH);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned MW = (CW > CfgWidth) ? CW : CfgWidth;
  localparam int unsigned HW = (IW > FillWidth) ? IW : FillWidth;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    logic [IW-1:0] r;
    if (idx == IW'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] free_cnt(input logic [IW-1:0] rd,
                                             input logic [IW-1:0] wr);
    logic [CW-1:0] r;
    if (rd > wr) begin
      r = CW'(rd) - CW'(wr);
    end else begin
      r = CW'(rd) + CW'(RING_DEPTH) - CW'(wr);
    end
    return r;
  endfunction

  function automatic logic [IW-1:0] held_cnt(input logic [IW-1:0] wr,
                                             input logic [IW-1:0] rd);
    logic [CW-1:0] r;
    if (wr >= rd) begin
      r = CW'(wr) - CW'(rd);
    end else begin
      r = CW'(wr) + CW'(RING_DEPTH) - CW'(rd);
    end
    return r[IW-1:0];
  endfunction

  surb_state_t state, state_next;

  logic [CfgWidth-1:0]  early_send_free;
  logic [IW-1:0]        wr_idx;
  logic [IW-1:0]        rd_idx;
  logic                 timer_on;

  logic                 a_action;
  logic [ByteWidth-1:0] a_byte;
  logic                 a_accept;

  logic                 st_dropped;
  logic                 st_refused;
  logic [FillWidth-1:0] st_fill;

  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        rd_left;
  logic [IW-1:0]        out_left;
  logic                 rd_pend;

  logic [ByteWidth-1:0] ram_rdata;

  logic                 in_take;
  logic                 out_free;
  logic                 ram_we;
  logic                 rd_issue;
  logic                 load_byte;
  logic                 load_stat;

  logic [IW-1:0]        w_cur;
  logic [CW-1:0]        free_now;
  logic                 attempt;
  logic                 empty;
  logic                 fwd;
  logic [IW-1:0]        len;
  logic                 do_send;
  logic                 refused;
  logic [IW-1:0]        rd_after;
  logic                 do_drop;
  logic [IW-1:0]        rd_new;
  logic                 timer_next;
  logic [HW-1:0]        fill_ext;

  always_comb begin
    w_cur    = a_action ? wr_idx : idx_inc(wr_idx);
    free_now = free_cnt(rd_idx, w_cur);
    attempt  = a_action ? timer_on : (MW'(free_now) < MW'(early_send_free));
    empty    = (w_cur == rd_idx);
    fwd      = (w_cur > rd_idx);
    len      = fwd ? (w_cur - rd_idx) : IW'(CW'(RING_DEPTH) - CW'(rd_idx));
    do_send  = attempt && !empty && a_accept;
    refused  = attempt && !empty && !a_accept;
    if (do_send) begin
      rd_after = fwd ? w_cur : '0;
    end else begin
      rd_after = rd_idx;
    end
    do_drop  = !a_action && refused && (free_now <= CW'(1));
    rd_new   = do_drop ? idx_inc(rd_idx) : rd_after;
    if (a_action) begin
      timer_next = timer_on && !(attempt && !refused && (w_cur == rd_after));
    end else begin
      timer_next = 1'b1;
    end
    fill_ext = HW'(held_cnt(w_cur, rd_new));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = do_send ? S_SEND : S_STAT;
      end
      S_STAT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SEND: begin
        if (load_byte && (out_left == IW'(1))) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_free  = !out_valid || !out_stall;
    in_stall  = (state != S_IDLE);
    in_take   = in_valid && !in_stall;
    ram_we    = (state == S_EVAL) && !a_action;
    load_stat = (state == S_STAT) && out_free;
    load_byte = (state == S_SEND) && rd_pend && out_free;
    rd_issue  = (state == S_SEND) && (rd_left != '0) && (!rd_pend || load_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      early_send_free <= EarlySendFreeReset;
    end else if (cfg_wr_en) begin
      early_send_free <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_action <= action;
      a_byte   <= rx_byte;
      a_accept <= usb_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx   <= '0;
      rd_idx   <= '0;
      timer_on <= 1'b0;
      rd_left  <= '0;
      out_left <= '0;
      rd_pend  <= 1'b0;
    end else begin
      if (state == S_EVAL) begin
        wr_idx   <= w_cur;
        rd_idx   <= rd_new;
        timer_on <= timer_next;
        rd_left  <= do_send ? len : '0;
        out_left <= do_send ? len : '0;
      end else begin
        if (rd_issue) begin
          rd_left <= rd_left - 1'b1;
        end
        if (load_byte) begin
          out_left <= out_left - 1'b1;
        end
      end
      if (rd_issue) begin
        rd_pend <= 1'b1;
      end else if (load_byte) begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      rd_addr    <= rd_idx;
      st_dropped <= do_drop;
      st_refused <= refused;
      st_fill    <= fill_ext[FillWidth-1:0];
    end else if (rd_issue) begin
      rd_addr <= rd_addr + 1'b1;
    end
  end

  surb_ram #(
    .WIDTH (ByteWidth),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (a_byte),
    .re    (rd_issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_stat || load_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_stat || load_byte) begin
      byte_valid    <= load_byte;
      tx_byte       <= load_byte ? ram_rdata : '0;
      last          <= load_stat || (out_left == IW'(1));
      dropped       <= st_dropped;
      send_refused  <= st_refused;
      timer_running <= timer_on;
      fill_level    <= st_fill;
    end
  end

  a_take_only_between_items : assert property (@(posedge clk) disable iff (rst)
    in_take |-> (out_left == '0) && !rd_pend)
    else $error("input word taken while a burst is still in progress");

  a_read_has_room : assert property (@(posedge clk) disable iff (rst)
    rd_issue |-> (rd_left <= out_left) && (state == S_SEND))
    else $error("RAM read issued beyond the burst length");

  a_pending_in_send : assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_SEND))
    else $error("read data pending outside a burst");

  a_burst_ends_last : assert property (@(posedge clk) disable iff (rst)
    (load_byte && (out_left == IW'(1))) |=> out_valid && last && byte_valid)
    else $error("final burst word not marked last");

endmodule

`default_nettype wire

FILE: hdl/surb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module surb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
